// ===== hw/rtl/cfe_pkg.sv =====
`default_nettype none

package cfe_pkg;

  // Byte and register widths fixed by the interface
  localparam int BYTE_W          = 8;
  localparam int FRAME_LEN_W     = 5;

  // Defaults
  localparam int MAX_PAYLOAD_DEF = 16;
  localparam int FRAME_LEN_RESET = 16;

  // COBS frame delimiter
  localparam logic [BYTE_W-1:0] DELIM_BYTE = 8'h00;

endpackage

`default_nettype wire

// ===== hw/rtl/cfe_run_buf.sv =====
`default_nettype none

module cfe_run_buf
  import cfe_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [IDX_W-1:0]  wr_addr,
  input  wire logic [BYTE_W-1:0] wr_data,
  input  wire logic [IDX_W-1:0]  rd_addr,
  output logic      [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [MAX_PAYLOAD];

  // Store run bytes as they arrive
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cfe_seq.sv =====
`default_nettype none

module cfe_seq
  import cfe_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1),
  localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [LEN_W-1:0]  eff_len,
  input  wire logic              data_valid,
  output logic                   data_stall,
  input  wire logic [BYTE_W-1:0] data_byte,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output logic      [BYTE_W-1:0] out_byte,
  output logic                   burst_last,
  output logic                   frame_end
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CODE,
    S_RUN,
    S_DELIM
  } state_t;

  state_t            state;
  logic [LEN_W-1:0]  run_len;
  logic [LEN_W-1:0]  frame_count;
  logic [IDX_W-1:0]  idx;
  logic [1:0]        flushes;
  logic              closing;

  logic              load;
  logic [LEN_W-1:0]  cnt_next;
  logic              close_now;
  logic              byte_zero;
  logic              room;
  logic [1:0]        flushes_new;
  logic              idx_last;
  logic              wr_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [BYTE_W-1:0] rd_data;

  // Output register is free or being emptied this cycle
  assign load = !result_valid || !result_stall;

  assign data_stall = (state != S_IDLE);

  // Frame and run bookkeeping for an incoming item
  assign cnt_next    = frame_count + LEN_W'(1);
  assign close_now   = (cnt_next >= eff_len);
  assign byte_zero   = (data_byte == '0);
  assign room        = (run_len < LEN_W'(MAX_PAYLOAD));
  assign flushes_new = 2'(byte_zero) + 2'(close_now);
  assign wr_en       = (state == S_IDLE) && data_valid && !byte_zero && room;

  assign idx_last = ((LEN_W'(idx) + LEN_W'(1)) == run_len);

  // Read address: prefetch the next run byte once the current one is loaded
  always_comb begin
    case (state)
      S_RUN:   rd_addr = load ? IDX_W'(idx + IDX_W'(1)) : idx;
      default: rd_addr = '0;
    endcase
  end

  cfe_run_buf #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_run_buf (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(run_len[IDX_W-1:0]),
    .wr_data(data_byte),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      run_len      <= '0;
      frame_count  <= '0;
      idx          <= '0;
      flushes      <= '0;
      closing      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          // Drop the held byte once it is taken
          if (load) begin
            result_valid <= 1'b0;
          end
          if (data_valid) begin
            frame_count <= close_now ? '0 : cnt_next;
            if (!byte_zero && room) begin
              run_len <= run_len + LEN_W'(1);
            end
            closing <= close_now;
            flushes <= flushes_new;
            if (flushes_new != 2'd0) begin
              state <= S_CODE;
            end
          end
        end
        S_CODE: begin
          if (load) begin
            result_valid <= 1'b1;
            out_byte     <= BYTE_W'(run_len) + BYTE_W'(1);
            frame_end    <= 1'b0;
            burst_last   <= (run_len == '0) && (flushes == 2'd1) && !closing;
            if (run_len != '0) begin
              idx   <= '0;
              state <= S_RUN;
            end else begin
              flushes <= flushes - 2'd1;
              if (flushes == 2'd1) begin
                state <= closing ? S_DELIM : S_IDLE;
              end
            end
          end
        end
        S_RUN: begin
          if (load) begin
            result_valid <= 1'b1;
            out_byte     <= rd_data;
            frame_end    <= 1'b0;
            burst_last   <= idx_last && (flushes == 2'd1) && !closing;
            if (idx_last) begin
              run_len <= '0;
              flushes <= flushes - 2'd1;
              if (flushes == 2'd1) begin
                state <= closing ? S_DELIM : S_IDLE;
              end else begin
                state <= S_CODE;
              end
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        S_DELIM: begin
          if (load) begin
            result_valid <= 1'b1;
            out_byte     <= DELIM_BYTE;
            frame_end    <= 1'b1;
            burst_last   <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cobs_frame_encoder.sv =====
`default_nettype none

// COBS encoder for fixed-length frames. Payload bytes enter one per item on
// the data channel; each run of non-zero bytes is held in a small buffer and
// goes out as a code byte (run length plus one) and the run when a zero byte
// arrives or the frame closes after frame_length bytes, the close adding a
// 0x00 delimiter flagged by frame_end. burst_last marks the last byte caused
// by one input item. A non-zero byte that does not close the frame produces
// nothing; otherwise the sequencer emits one byte per cycle while the result
// side does not stall, through a single output register, up to MAX_PAYLOAD + 2
// result bytes for one item. The data channel stalls until the last byte of an
// item is loaded. A frame_length of 0 acts as 1 and values above MAX_PAYLOAD
// act as MAX_PAYLOAD.

module cobs_frame_encoder
  import cfe_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [FRAME_LEN_W-1:0] frame_length,
  input  wire logic                   data_valid,
  output logic                        data_stall,
  input  wire logic [BYTE_W-1:0]      data_byte,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output logic      [BYTE_W-1:0]      out_byte,
  output logic                        burst_last,
  output logic                        frame_end
);

  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam logic [LEN_W-1:0] LEN_RESET = (FRAME_LEN_RESET > MAX_PAYLOAD) ?
                                           LEN_W'(MAX_PAYLOAD) : LEN_W'(FRAME_LEN_RESET);

  logic [LEN_W-1:0] eff_len;
  logic [LEN_W-1:0] len_clamped;

  assign cfg_ready = 1'b1;

  // Saturate the written length into the supported range
  always_comb begin
    if (frame_length == '0) begin
      len_clamped = LEN_W'(1);
    end else if (int'(frame_length) > MAX_PAYLOAD) begin
      len_clamped = LEN_W'(MAX_PAYLOAD);
    end else begin
      len_clamped = LEN_W'(frame_length);
    end
  end

  // Hold the effective frame length
  always_ff @(posedge clk) begin
    if (rst) begin
      eff_len <= LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      eff_len <= len_clamped;
    end
  end

  cfe_seq #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .eff_len     (eff_len),
    .data_valid  (data_valid),
    .data_stall  (data_stall),
    .data_byte   (data_byte),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .out_byte    (out_byte),
    .burst_last  (burst_last),
    .frame_end   (frame_end)
  );

endmodule

`default_nettype wire

// ===== verif/cobs_frame_encoder_tb.sv =====
`timescale 1ns / 100ps

module cobs_frame_encoder_tb;
  import cfe_pkg::*;

  localparam int MAX_PAYLOAD   = MAX_PAYLOAD_DEF;
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT   = 500000;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              burst_last;
    logic              frame_end;
  } enc_byte_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [FRAME_LEN_W-1:0] frame_length = '0;
  logic                   data_valid = 1'b0;
  logic                   data_stall;
  logic [BYTE_W-1:0]      data_byte = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic [BYTE_W-1:0]      out_byte;
  logic                   burst_last;
  logic                   frame_end;

  // Encoder state mirrored for prediction
  logic [BYTE_W-1:0]      run_bytes [MAX_PAYLOAD];
  int                     run_count = 0;
  int                     frame_bytes = 0;
  logic [FRAME_LEN_W-1:0] len_reg = FRAME_LEN_W'(FRAME_LEN_RESET);

  enc_byte_t encoded_q[$];
  int        mismatch_cnt = 0;
  int        cycle_cnt = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;

  cobs_frame_encoder dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .frame_length (frame_length),
    .data_valid   (data_valid),
    .data_stall   (data_stall),
    .data_byte    (data_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .burst_last   (burst_last),
    .frame_end    (frame_end)
  );

  always #2 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Randomly stall the result side
  always @(posedge clk) begin
    result_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // Compare each accepted result with the oldest predicted byte
  always @(posedge clk) begin
    enc_byte_t want;
    if (!rst && result_valid && !result_stall) begin
      if (encoded_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected result out_byte=%h burst_last=%b frame_end=%b",
                 $time, out_byte, burst_last, frame_end);
      end else begin
        want = encoded_q.pop_front();
        if (out_byte !== want.out_byte) begin
          mismatch_cnt++;
          $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, out_byte);
        end
        if (burst_last !== want.burst_last) begin
          mismatch_cnt++;
          $display("%0t: burst_last expected %b actual %b", $time, want.burst_last,
                   burst_last);
        end
        if (frame_end !== want.frame_end) begin
          mismatch_cnt++;
          $display("%0t: frame_end expected %b actual %b", $time, want.frame_end,
                   frame_end);
        end
      end
    end
  end

  // Emit code byte and buffered run, then start a new run
  function automatic void flush_run(ref enc_byte_t burst[$]);
    burst.push_back('{out_byte: BYTE_W'(run_count + 1), burst_last: 1'b0, frame_end: 1'b0});
    for (int i = 0; i < run_count; i++)
      burst.push_back('{out_byte: run_bytes[i], burst_last: 1'b0, frame_end: 1'b0});
    run_count = 0;
  endfunction

  // Predict the encoded bytes caused by one payload byte
  function automatic void encode_payload_byte(input logic [BYTE_W-1:0] b);
    enc_byte_t burst[$];
    int        eff_len;
    frame_bytes++;
    if (b != '0) begin
      if (run_count < MAX_PAYLOAD) begin
        run_bytes[run_count] = b;
        run_count++;
      end
    end else begin
      flush_run(burst);
    end
    // Saturate the frame length into 1..MAX_PAYLOAD
    if (len_reg == '0)
      eff_len = 1;
    else if (int'(len_reg) > MAX_PAYLOAD)
      eff_len = MAX_PAYLOAD;
    else
      eff_len = int'(len_reg);
    if (frame_bytes >= eff_len) begin
      flush_run(burst);
      burst.push_back('{out_byte: DELIM_BYTE, burst_last: 1'b0, frame_end: 1'b1});
      frame_bytes = 0;
    end
    if (burst.size() > 0)
      burst[burst.size() - 1].burst_last = 1'b1;
    foreach (burst[i])
      encoded_q.push_back(burst[i]);
  endfunction

  // Offer one payload byte, with random idle cycles ahead of it
  task automatic send_payload_byte(input logic [BYTE_W-1:0] b);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      data_valid <= 1'b0;
      @(posedge clk);
    end
    data_valid <= 1'b1;
    data_byte  <= b;
    @(posedge clk);
    while (data_stall)
      @(posedge clk);
    encode_payload_byte(b);
  endtask

  // Hold the sender until every predicted byte is out and the encoder is idle
  task automatic settle_encoder();
    data_valid <= 1'b0;
    while (encoded_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_frame_length(input logic [FRAME_LEN_W-1:0] v);
    settle_encoder();
    cfg_valid    <= 1'b1;
    frame_length <= v;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    len_reg = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte(input int zero_pct);
    int sel;
    if ($urandom_range(99) < zero_pct)
      return '0;
    sel = $urandom_range(9);
    if (sel == 0)
      return 8'hFF;
    if (sel == 1)
      return 8'h01;
    return BYTE_W'($urandom_range(255, 1));
  endfunction

  // Longest run at reset length: sixteen non-zero bytes in one frame
  task automatic test_full_run_frame();
    logic [BYTE_W-1:0] b;
    for (int i = 0; i < MAX_PAYLOAD; i++) begin
      case (i)
        0:       b = 8'hFF;
        1:       b = 8'h01;
        2:       b = 8'h80;
        3:       b = 8'h7F;
        default: b = BYTE_W'($urandom_range(255, 1));
      endcase
      send_payload_byte(b);
    end
    settle_encoder();
  endtask

  // Length 0 acts as one byte per frame
  task automatic test_length_floor();
    write_frame_length('0);
    send_payload_byte(8'h00);
    send_payload_byte(8'h7F);
    settle_encoder();
  endtask

  // Zero as the last byte of a frame adds an empty closing run
  task automatic test_zero_last_byte();
    write_frame_length(FRAME_LEN_W'(2));
    send_payload_byte(8'h05);
    send_payload_byte(8'h00);
    settle_encoder();
  endtask

  // Lower the length below the bytes already taken; next byte closes
  task automatic test_lowered_length();
    write_frame_length(FRAME_LEN_W'(4));
    send_payload_byte(8'h11);
    send_payload_byte(8'h22);
    write_frame_length(FRAME_LEN_W'(1));
    send_payload_byte(8'h33);
    settle_encoder();
  endtask

  task automatic run_phase(input logic [FRAME_LEN_W-1:0] len, input int n_items,
                           input int idle, input int stall, input int zero_pct,
                           input bit pause_midway);
    write_frame_length(len);
    send_idle_pct = idle;
    stall_pct     = stall;
    for (int i = 0; i < n_items; i++) begin
      // Let the whole backlog drain once with the sender held off
      if (pause_midway && i == n_items / 2)
        settle_encoder();
      send_payload_byte(pick_byte(zero_pct));
    end
    settle_encoder();
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  // Random traffic over several lengths and idling mixes
  task automatic test_random_frames();
    run_phase(FRAME_LEN_W'(16), 80, 0,  0,  20, 1'b0);
    run_phase(FRAME_LEN_W'(1),  50, 47, 0,  30, 1'b0);
    run_phase(FRAME_LEN_W'(31), 70, 0,  47, 10, 1'b0);
    run_phase(FRAME_LEN_W'(5),  70, 16, 16, 35, 1'b0);
    run_phase(FRAME_LEN_W'(17), 60, 47, 47, 5,  1'b0);
    run_phase(FRAME_LEN_W'(0),  30, 0,  0,  50, 1'b0);
    run_phase(FRAME_LEN_W'(9),  70, 47, 0,  25, 1'b1);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_full_run_frame();
    test_length_floor();
    test_zero_last_byte();
    test_lowered_length();
    test_random_frames();
    settle_encoder();
    if (mismatch_cnt == 0 && encoded_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
